// ===== design/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants for the 3x3 median filter: beat payloads,
// configuration register indices, window and stage control types.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W        = 16;
  localparam int IMG_WIDTH_W  = 12;
  localparam int IMG_HEIGHT_W = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMG_HEIGHT = 2'd1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic func;
    pix_t pixel;
  } pix_item_t;

  typedef struct packed {
    pix_t out_pixel;
    logic last_of_frame;
  } res_item_t;

  // [row][column], column 2 is the newest
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic emit;      // this beat produces a result
    logic last;      // final pixel of the plane
    logic interior;  // take the median, else take alt
    pix_t alt;       // pass-through value
  } med_ctrl_t;

endpackage

// ===== design/mf3_ram.sv =====
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mf3_median_pipe.sv =====
// ----------------------------------------------------------------------------
// mf3_median_pipe
// Two-stage median of a 3x3 window: row sorts, then max of lows, median of
// mids and min of highs, whose median is the median of all nine.
// ----------------------------------------------------------------------------
module mf3_median_pipe (
  input  logic                clk,
  input  logic                rst,
  input  mf3_pkg::window_t    window,
  input  mf3_pkg::med_ctrl_t  ctrl,
  output logic                push,
  output mf3_pkg::res_item_t  push_item,
  output logic [1:0]          busy_emits
);

  function automatic mf3_pkg::pix_t max2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic mf3_pkg::pix_t min2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3_pkg::pix_t med3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
                                        input mf3_pkg::pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  mf3_pkg::pix_t      lo [3];
  mf3_pkg::pix_t      md [3];
  mf3_pkg::pix_t      hi [3];
  mf3_pkg::med_ctrl_t s3_ctrl;
  mf3_pkg::pix_t      lo_max;
  mf3_pkg::pix_t      md_med;
  mf3_pkg::pix_t      hi_min;
  mf3_pkg::med_ctrl_t s4_ctrl;

  // stage 3: sort each row
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      lo[r] <= min2(min2(window[r][0], window[r][1]), window[r][2]);
      hi[r] <= max2(max2(window[r][0], window[r][1]), window[r][2]);
      md[r] <= med3(window[r][0], window[r][1], window[r][2]);
    end
    s3_ctrl.last     <= ctrl.last;
    s3_ctrl.interior <= ctrl.interior;
    s3_ctrl.alt      <= ctrl.alt;
  end

  // stage 4: reduce to three candidates
  always_ff @(posedge clk) begin
    lo_max           <= max2(max2(lo[0], lo[1]), lo[2]);
    md_med           <= med3(md[0], md[1], md[2]);
    hi_min           <= min2(min2(hi[0], hi[1]), hi[2]);
    s4_ctrl.last     <= s3_ctrl.last;
    s4_ctrl.interior <= s3_ctrl.interior;
    s4_ctrl.alt      <= s3_ctrl.alt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctrl.emit <= 1'b0;
      s4_ctrl.emit <= 1'b0;
    end else begin
      s3_ctrl.emit <= ctrl.emit;
      s4_ctrl.emit <= s3_ctrl.emit;
    end
  end

  assign push                    = s4_ctrl.emit;
  assign push_item.out_pixel     = s4_ctrl.interior ? med3(lo_max, md_med, hi_min)
                                                    : s4_ctrl.alt;
  assign push_item.last_of_frame = s4_ctrl.last;
  assign busy_emits              = {1'b0, s3_ctrl.emit} + {1'b0, s4_ctrl.emit};

endmodule

// ===== design/median_filter_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// 3x3 median filter over one image plane streamed in raster order.
// ----------------------------------------------------------------------------
// Pixel beats (func = pixel) arrive on pix_*, results leave on res_*; both
// use valid/stall. Interior pixels become the median of their neighbourhood,
// border pixels and planes narrower or lower than 3 pass through. A result
// trails its pixel by img_width+1 beats; after the last pixel, drain beats
// (func = drain) release the pending results one each. last_of_frame marks
// the final pixel of the plane.
// Throughput: one beat per cycle while pix_stall is low. A result shows on
// res_valid once the beat that releases it has passed the line store
// read, window update, two median stages and the result queue.
// When res_stall is held, an 8-entry result queue absorbs the beats in
// flight and pix_stall rises once the queue plus the pipeline would fill.
// cfg_* writes img_width (index 0) or img_height (index 1) and restarts the
// plane, dropping pending results; pix_stall is high while cfg_valid is.
// Reset restores 3x3 geometry and empties the pipeline. The line store is
// not cleared: each entry is written before any read that feeds a result.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  mf3_pkg::pix_item_t                  pix_data,
  output logic                                res_valid,
  input  logic                                res_stall,
  output mf3_pkg::res_item_t                  res_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mf3_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (WW > mf3_pkg::IMG_WIDTH_W) ? WW : mf3_pkg::IMG_WIDTH_W;
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W  = mf3_pkg::IMG_HEIGHT_W;
  localparam int PIX_W  = mf3_pkg::PIX_W;
  localparam int CNT_W  = $clog2(mf3_pkg::FIFO_DEPTH + 1);
  localparam int LVL_W  = $clog2(mf3_pkg::FIFO_DEPTH + 5);

  // configuration and position state
  logic [mf3_pkg::IMG_WIDTH_W-1:0]  img_width;
  logic [mf3_pkg::IMG_HEIGHT_W-1:0] img_height;
  logic [COL_W-1:0]                 in_col;
  logic [ROW_W-1:0]                 in_row;
  logic [COL_W-1:0]                 out_col;
  logic [ROW_W-1:0]                 out_row;
  logic [PEND_W-1:0]                pending;

  logic [CMP_W-1:0] width_ext;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  logic             pix_take;
  logic             cfg_take;
  logic             restart;
  logic             is_drain;
  logic             lag_full;
  logic             pend_zero;
  logic             emit_now;
  logic             interior_now;
  logic             last_now;
  logic             in_col_last;
  logic             in_row_last;
  logic             out_col_last;
  logic             out_row_last;
  logic [COL_W-1:0] ram_addr;

  // stage 1: line store data returns
  logic             s1_valid;
  logic             s1_drain;
  logic             s1_emit;
  logic             s1_interior;
  logic             s1_last;
  logic             s1_sel_upper;
  logic [COL_W-1:0] s1_col;
  mf3_pkg::pix_t    s1_pixel;
  logic             fwd_hit;
  mf3_pkg::pix_t    fwd_upper;
  mf3_pkg::pix_t    fwd_middle;
  mf3_pkg::pix_t    up_eff;
  mf3_pkg::pix_t    mid_eff;
  logic             ram_we;
  logic [2*PIX_W-1:0] ram_rdata;

  // stage 2: window
  mf3_pkg::window_t   window;
  mf3_pkg::med_ctrl_t s2_ctrl;

  logic               push;
  mf3_pkg::res_item_t push_item;
  logic [1:0]         busy_emits;

  // result queue
  mf3_pkg::res_item_t                fifo_mem [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_PTR_W-1:0]    wr_ptr;
  logic [mf3_pkg::FIFO_PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]                  fifo_count;
  logic                              pop;
  logic [2:0]                        inflight;
  logic [LVL_W-1:0]                  level;

  always_comb begin
    width_ext = CMP_W'(img_width);
    if (img_width == '0) begin
      w_eff = WW'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_ext);
    end
    h_eff = (img_height == '0) ? ROW_W'(1) : img_height;
  end

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign restart   = cfg_take & ((cfg_index == mf3_pkg::CFG_IMG_WIDTH) ||
                                 (cfg_index == mf3_pkg::CFG_IMG_HEIGHT));

  assign inflight  = 3'(s1_valid & s1_emit) + 3'(s2_ctrl.emit) + 3'(busy_emits);
  assign level     = LVL_W'(fifo_count) + LVL_W'(inflight);
  assign pix_stall = (level >= LVL_W'(mf3_pkg::FIFO_DEPTH)) | cfg_valid;
  assign pix_take  = pix_valid & ~pix_stall;

  assign is_drain     = pix_data.func == mf3_pkg::FUNC_DRAIN;
  assign lag_full     = pending > PEND_W'(w_eff);
  assign pend_zero    = pending == '0;
  assign emit_now     = is_drain ? ~pend_zero : lag_full;
  assign in_col_last  = (WW'(in_col) + WW'(1)) == w_eff;
  assign in_row_last  = (in_row + ROW_W'(1)) == h_eff;
  assign out_col_last = (WW'(out_col) + WW'(1)) == w_eff;
  assign out_row_last = (out_row + ROW_W'(1)) == h_eff;
  assign last_now     = out_col_last & out_row_last;
  assign interior_now = ~is_drain && (w_eff >= WW'(3)) && (h_eff >= ROW_W'(3)) &&
                        (out_col != '0) && ((WW'(out_col) + WW'(1)) < w_eff) &&
                        (out_row != '0) && ((out_row + ROW_W'(1)) < h_eff);
  assign ram_addr     = is_drain ? out_col : in_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= mf3_pkg::IMG_WIDTH_W'(3);
      img_height <= mf3_pkg::IMG_HEIGHT_W'(3);
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      pending    <= '0;
    end else if (restart) begin
      if (cfg_index == mf3_pkg::CFG_IMG_WIDTH) begin
        img_width <= cfg_wdata[mf3_pkg::IMG_WIDTH_W-1:0];
      end else begin
        img_height <= cfg_wdata[mf3_pkg::IMG_HEIGHT_W-1:0];
      end
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else if (pix_take) begin
      if (!is_drain) begin
        if (in_col_last) begin
          in_col <= '0;
          in_row <= in_row_last ? '0 : in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (!lag_full) begin
          pending <= pending + PEND_W'(1);
        end
      end else if (!pend_zero) begin
        pending <= pending - PEND_W'(1);
      end
      if (emit_now) begin
        if (out_col_last) begin
          out_col <= '0;
          out_row <= out_row_last ? '0 : out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= pix_take;
      s1_emit  <= pix_take & emit_now;
      // the beat in stage 1 writes its column at this edge, after the read
      fwd_hit  <= s1_valid & ~s1_drain & (s1_col == ram_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_drain     <= is_drain;
    s1_interior  <= interior_now;
    s1_last      <= last_now;
    s1_sel_upper <= lag_full;
    s1_col       <= ram_addr;
    s1_pixel     <= pix_data.pixel;
    fwd_upper    <= mid_eff;
    fwd_middle   <= s1_pixel;
  end

  assign up_eff  = fwd_hit ? fwd_upper  : ram_rdata[2*PIX_W-1:PIX_W];
  assign mid_eff = fwd_hit ? fwd_middle : ram_rdata[PIX_W-1:0];
  assign ram_we  = s1_valid & ~s1_drain;

  // upper half: older pixel of the column, lower half: newer
  mf3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata ({mid_eff, s1_pixel}),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // stage 2: window shift and pass-through value
  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      s2_ctrl.emit <= 1'b0;
    end else begin
      s2_ctrl.emit <= s1_valid & s1_emit;
      if (ram_we) begin
        for (int r = 0; r < 3; r++) begin
          window[r][0] <= window[r][1];
          window[r][1] <= window[r][2];
        end
        window[0][2] <= up_eff;
        window[1][2] <= mid_eff;
        window[2][2] <= s1_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_ctrl.last     <= s1_last;
    s2_ctrl.interior <= s1_interior;
    if (s1_drain) begin
      s2_ctrl.alt <= s1_sel_upper ? up_eff : mid_eff;
    end else begin
      s2_ctrl.alt <= window[1][2];  // becomes the centre after the shift
    end
  end

  mf3_median_pipe u_median (
    .clk        (clk),
    .rst        (rst),
    .window     (window),
    .ctrl       (s2_ctrl),
    .push       (push),
    .push_item  (push_item),
    .busy_emits (busy_emits)
  );

  // result queue
  assign res_valid = fifo_count != '0;
  assign res_data  = fifo_mem[rd_ptr];
  assign pop       = res_valid & ~res_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mf3_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mf3_pkg::FIFO_PTR_W'(1);
      end
      fifo_count <= fifo_count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ===== design/mf3_checker.sv =====
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks for the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3_checker (
  input logic               clk,
  input logic               rst,
  input logic               pix_stall,
  input logic               res_valid,
  input logic               res_stall,
  input mf3_pkg::res_item_t res_data,
  input logic               cfg_valid
);

  // nothing can reach the output after reset until a beat has passed the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid ##1 !res_valid ##1 !res_valid)
    else $error("result beat too soon after reset");

  // an empty result queue always leaves room for the pipeline
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    (!res_valid && !cfg_valid) |-> !pix_stall)
    else $error("input stalled with empty result queue");

  a_cfg_blocks_pixels: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> pix_stall)
    else $error("pixel beat open during configuration write");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
    else $error("stalled result beat changed");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data),
  .cfg_valid (cfg_valid)
);

// ===== sim/median_filter_3x3_unit_checker.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_unit_checker
// Watches the pixel, result and register channels of the median filter. It
// keeps its own copy of the line stores, window and raster counters, works
// out the filtered pixels, and compares every result beat with the oldest
// one still due.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit_checker
  import mf3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  input  logic                   pix_stall,
  input  pix_item_t              pix_data,
  input  logic                   res_valid,
  input  logic                   res_stall,
  input  res_item_t              res_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS = 2048;

  logic [IMG_WIDTH_W-1:0]  width_reg;
  logic [IMG_HEIGHT_W-1:0] height_reg;
  pix_t                    top_line [MAX_COLS];
  pix_t                    mid_line [MAX_COLS];
  pix_t                    win [3][3];
  int unsigned             in_col, in_row, out_col, out_row, pend;
  int                      mismatches;
  res_item_t               median_due [$];

  function automatic int unsigned cols_now();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return width_reg;
  endfunction

  function automatic int unsigned rows_now();
    return (height_reg == '0) ? 1 : height_reg;
  endfunction

  function automatic pix_t median_of();
    pix_t v [9];
    pix_t t;
    for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
    for (int i = 1; i < 9; i++) begin
      for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
        t = v[j];
        v[j] = v[j-1];
        v[j-1] = t;
      end
    end
    return v[4];
  endfunction

  task automatic advance(inout int unsigned col, inout int unsigned row,
                         input int unsigned w, input int unsigned h);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  task automatic release_px(input pix_t v, input int unsigned w, input int unsigned h);
    res_item_t r;
    r.out_pixel     = v;
    r.last_of_frame = (out_col + 1 == w) && (out_row + 1 == h);
    median_due.push_back(r);
    advance(out_col, out_row, w, h);
  endtask

  task automatic take_reg(input logic [CFG_INDEX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_IMG_WIDTH:  width_reg  = d[IMG_WIDTH_W-1:0];
      CFG_IMG_HEIGHT: height_reg = d[IMG_HEIGHT_W-1:0];
      default:        return;
    endcase
    // any geometry write restarts the plane and drops what is pending
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    pend    = 0;
  endtask

  task automatic filter_beat(input pix_item_t b);
    int unsigned w, h, cx;
    w = cols_now();
    h = rows_now();
    if (b.func == FUNC_DRAIN) begin
      if (pend != 0 && out_col < w && in_col < w) begin
        // a full lag means the oldest pixel has already moved to the upper line
        release_px((pend <= w) ? mid_line[out_col] : top_line[out_col], w, h);
        pend--;
      end
      return;
    end
    cx = (in_col >= w) ? 0 : in_col;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2]    = top_line[cx];
    win[1][2]    = mid_line[cx];
    win[2][2]    = b.pixel;
    top_line[cx] = mid_line[cx];
    mid_line[cx] = b.pixel;
    advance(in_col, in_row, w, h);
    if (pend < w + 1) begin
      pend++;
    end else if (w >= 3 && h >= 3 && out_col >= 1 && out_col + 2 <= w &&
                 out_row >= 1 && out_row + 2 <= h) begin
      release_px(median_of(), w, h);
    end else begin
      release_px(win[1][1], w, h);
    end
  endtask

  task automatic check_result(input res_item_t got);
    res_item_t want;
    if (median_due.size() == 0) begin
      $error("result beat with nothing due: out_pixel %0h last_of_frame %0b",
             got.out_pixel, got.last_of_frame);
      mismatches++;
    end else begin
      want = median_due.pop_front();
      if (got.out_pixel !== want.out_pixel) begin
        $error("out_pixel: expected %0h, actual %0h", want.out_pixel, got.out_pixel);
        mismatches++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $error("last_of_frame: expected %0b, actual %0b",
               want.last_of_frame, got.last_of_frame);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = IMG_WIDTH_W'(3);
      height_reg = IMG_HEIGHT_W'(3);
      for (int i = 0; i < MAX_COLS; i++) begin
        top_line[i] = '0;
        mid_line[i] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      end
      in_col     = 0;
      in_row     = 0;
      out_col    = 0;
      out_row    = 0;
      pend       = 0;
      mismatches = 0;
      median_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) take_reg(cfg_index, cfg_wdata);
      if (pix_valid && !pix_stall) filter_beat(pix_data);
      if (res_valid && !res_stall) check_result(res_data);
    end
    fail_count <= mismatches;
    due_count  <= median_due.size();
  end

endmodule

// ===== sim/median_filter_3x3_unit_tb.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_unit_tb
// Drives planes of pixels and drain beats through the median filter under
// a range of geometries, with random gaps on the pixel side and random
// stalls on the result side; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int RANDOM_ITEMS  = 1650;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_COLS      = 2048;

  // indices past the register list, which the block must ignore
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   pix_valid = 1'b0;
  logic                   pix_stall;
  pix_item_t              pix_data  = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  res_item_t              res_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int   fail_count;
  int   due_count;
  logic calm          = 1'b0;
  logic hold_off_req  = 1'b0;
  int   beats_done    = 0;
  int   cols          = 3;
  int   rows          = 3;

  median_filter_3x3_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  median_filter_3x3_unit_checker median_check (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: stall bursts, one long hold-off on request, none when calm
  initial begin : result_side
    int n;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_stall    = 1'b1;
        n            = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_stall = 1'b1;
        n         = $urandom_range(1, 7);
      end else begin
        res_stall = 1'b0;
        n         = $urandom_range(1, 12);
      end
      repeat (n) @(negedge clk);
    end
  end

  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return pix_t'($urandom_range(0, 3));
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic int cols_of(input logic [IMG_WIDTH_W-1:0] w);
    if (w == '0) return 1;
    if (w > MAX_COLS) return MAX_COLS;
    return w;
  endfunction

  task automatic put_beat(input logic f, input pix_t p);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pix_valid = 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    pix_valid      = 1'b1;
    pix_data.func  = f;
    pix_data.pixel = p;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  // wait for every due result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    pix_valid = 1'b0;
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [IMG_WIDTH_W-1:0] w,
                              input logic [IMG_HEIGHT_W-1:0] h);
    logic [CFG_DATA_W-1:0] d;
    settle();
    d = CFG_DATA_W'($urandom);   // upper bits of the width write are don't-care
    d[IMG_WIDTH_W-1:0] = w;
    write_reg(CFG_IMG_WIDTH, d);
    write_reg(CFG_IMG_HEIGHT, h);
    cols = cols_of(w);
    rows = (h == '0) ? 1 : h;
  endtask

  task automatic feed_pixels(input int n);
    int stop_at;
    stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == stop_at) begin
        // mid-plane pause until idle; a spare-index write must not restart
        settle();
        if ($urandom_range(0, 1) == 1)
          write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                    CFG_DATA_W'($urandom));
      end
      put_beat(FUNC_PIXEL, pick_pixel());
      beats_done++;
    end
  endtask

  task automatic drain_pending(input int n);
    for (int i = 0; i < n; i++) begin
      put_beat(FUNC_DRAIN, pix_t'($urandom));
      beats_done++;
    end
  endtask

  initial begin : stimulus
    pix_t corner_set [9];
    int   kind, n, planes;
    logic [IMG_WIDTH_W-1:0]  wr;
    logic [IMG_HEIGHT_W-1:0] hr;

    corner_set = '{16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000,
                   16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry is 3x3: one full plane, its four pending results drained, then a drain with nothing pending
    foreach (corner_set[i]) put_beat(FUNC_PIXEL, corner_set[i]);
    for (int i = 0; i < 4; i++) put_beat(FUNC_DRAIN, 16'hFFFF);
    put_beat(FUNC_DRAIN, 16'h0000);

    // zero width and height both behave as one
    set_geometry('0, '0);
    put_beat(FUNC_PIXEL, 16'hFFFF);
    put_beat(FUNC_PIXEL, 16'h0000);
    put_beat(FUNC_DRAIN, 16'h0000);
    put_beat(FUNC_DRAIN, 16'hFFFF);

    // early drain part way through a plane, then pixels resume
    set_geometry(3, 3);
    for (int i = 0; i < 4; i++) put_beat(FUNC_PIXEL, pick_pixel());
    put_beat(FUNC_DRAIN, 16'h5A5A);
    put_beat(FUNC_PIXEL, 16'hFFFF);
    put_beat(FUNC_PIXEL, 16'h0001);

    // long hold-off on the result side while pixels keep coming
    set_geometry(5, 9);
    hold_off_req = 1'b1;
    feed_pixels(45);
    drain_pending(6);

    while (beats_done < RANDOM_ITEMS) begin
      calm = (beats_done > RANDOM_ITEMS * 17 / 20);
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        set_geometry($urandom_range(1, 8), $urandom_range(1, 6));
        planes = $urandom_range(1, 3);
        for (int p = 0; p < planes; p++) feed_pixels(cols * rows);
        drain_pending(cols + 1);
        if ($urandom_range(0, 3) == 0) put_beat(FUNC_DRAIN, pix_t'($urandom));
      end else if (kind < 13) begin
        set_geometry($urandom_range(9, 40), $urandom_range(3, 5));
        feed_pixels(cols * rows);
        drain_pending(cols + 1);
      end else if (kind < 15) begin
        // noise: pixels and drains mixed at random, plane left unfinished
        set_geometry($urandom_range(1, 6), $urandom_range(1, 6));
        n = $urandom_range(10, 40);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 2) == 0) put_beat(FUNC_DRAIN, pix_t'($urandom));
          else put_beat(FUNC_PIXEL, pick_pixel());
        end
        beats_done += n;
      end else if (kind < 17) begin
        // broken plane: early drains, more pixels, then cut off by a restart
        set_geometry($urandom_range(3, 7), $urandom_range(3, 6));
        feed_pixels($urandom_range(1, cols * rows - 1));
        drain_pending($urandom_range(1, 3));
        feed_pixels($urandom_range(1, 2 * cols));
      end else if (kind == 17) begin
        case ($urandom_range(0, 3))
          0:       wr = 2047;
          1:       wr = 2048;
          2:       wr = 2049;
          default: wr = '1;
        endcase
        set_geometry(wr, $urandom_range(1, 3));
        n = $urandom_range(30, 60);
        feed_pixels(n);
        drain_pending(n);
      end else if (kind == 18) begin
        case ($urandom_range(0, 2))
          0:       hr = '0;
          1:       hr = '1;
          default: hr = 16'hFFFE;
        endcase
        set_geometry($urandom_range(3, 5), hr);
        feed_pixels(cols * $urandom_range(1, 4));
        drain_pending(cols + 1);
      end else begin
        set_geometry($urandom_range(0, 1) ? '0 : IMG_WIDTH_W'($urandom_range(1, 4)),
                     $urandom_range(0, 1) ? '0 : IMG_HEIGHT_W'($urandom_range(1, 4)));
        feed_pixels(cols * rows * $urandom_range(1, 3));
        drain_pending(cols + 1);
      end
    end

    settle();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== median_filter_3x3_unit.f =====
design/mf3_pkg.sv
design/mf3_ram.sv
design/mf3_median_pipe.sv
design/median_filter_3x3_unit.sv
design/mf3_checker.sv
sim/median_filter_3x3_unit_checker.sv
sim/median_filter_3x3_unit_tb.sv
